// File: rtl/jsu_pkg.sv
package jsu_pkg;

    // Decoder phase codes
    typedef enum logic [2:0] {
        PH_TEXT    = 3'd0,
        PH_ESC     = 3'd1,
        PH_HEX     = 3'd2,
        PH_SUR_BS  = 3'd3,
        PH_SUR_U   = 3'd4,
        PH_SUR_HEX = 3'd5
    } jsu_phase_t;

    // Characters and bytes of interest
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_U        = 8'h75;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CASE_MASK   = 8'hDF;
    localparam logic [7:0] ALPHA_SHIFT = 8'h07;

    localparam logic [15:0] SUR_MASK = 16'hFC00;
    localparam logic [15:0] SUR_HIGH = 16'hD800;

    localparam logic [20:0] CP_LIM1 = 21'h00080;
    localparam logic [20:0] CP_LIM2 = 21'h00800;
    localparam logic [20:0] CP_LIM3 = 21'h10000;

    localparam logic [1:0] HEX_LAST = 2'd3;

    // Up to four output bytes with their count
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } jsu_utf8_t;

    // Result group of one input transaction
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            eos;
    } jsu_group_t;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (c >= CH_UPPER_A) begin
            v = (c & CASE_MASK) - ALPHA_SHIFT;
        end
        v = v - CH_ZERO;
        return v[3:0];
    endfunction

    function automatic logic [7:0] escape_byte(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h72:   r = 8'h0D;   // r
            8'h6E:   r = 8'h0A;   // n
            8'h5C:   r = 8'h5C;   // backslash
            8'h2F:   r = 8'h2F;   // slash
            8'h22:   r = 8'h22;   // quote
            8'h66:   r = 8'h0C;   // f
            8'h62:   r = 8'h08;   // b
            8'h74:   r = 8'h09;   // t
            default: r = CH_QMARK;
        endcase
        return r;
    endfunction

    function automatic jsu_utf8_t utf8_encode(input logic [20:0] cp);
        jsu_utf8_t r;
        r.bytes = '0;
        if (cp < CP_LIM1) begin
            r.bytes[0] = cp[7:0];
            r.count    = 3'd1;
        end else if (cp < CP_LIM2) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.count    = 3'd2;
        end else if (cp < CP_LIM3) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.count    = 3'd3;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.count    = 3'd4;
        end
        return r;
    endfunction

endpackage

// File: rtl/json_string_unescape_decoder.sv
// Channel  | Dir | Signals                  | Contents
// s_       | in  | tvalid tready tdata tlast | escaped byte, end of string on tlast
// m_       | out | tvalid tready tdata tuser tlast | unescaped byte, string done on tlast
//
// One input transaction is accepted per cycle when it yields at most one byte and the
// output is ready. An escape or surrogate pair that yields N bytes (up to 4) holds the
// output until all N are taken; the input stalls while more than one byte is still
// queued or the held byte is not taken. The first byte shows in the cycle after accept.
// aresetn (synchronous, active low) returns the decoder to plain text state.
// Output stalls hold the current byte; the next group loads as its last byte leaves.
module json_string_unescape_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] last_of_run, [15:9] zero
    output logic        m_tuser,   // [0] byte_valid
    output logic        m_tlast    // string_done
);
    import jsu_pkg::*;

    jsu_group_t group;
    logic       s_fire;
    logic       load_ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    assign s_tready = load_ready;
    assign s_fire   = s_tvalid && load_ready;

    jsu_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (s_fire),
        .in_byte (s_tdata),
        .in_eos  (s_tlast),
        .group   (group)
    );

    jsu_serializer u_serializer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (s_fire),
        .group           (group),
        .load_ready      (load_ready),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_byte        (out_byte),
        .out_byte_valid  (m_tuser),
        .out_done        (m_tlast),
        .out_last_of_run (last_of_run)
    );

    assign m_tdata = {7'd0, last_of_run, out_byte};

endmodule

// File: rtl/jsu_decode.sv
module jsu_decode (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic [7:0]         in_byte,
    input  logic               in_eos,
    output jsu_pkg::jsu_group_t group
);
    import jsu_pkg::*;

    jsu_phase_t  phase_reg, phase_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] unit_accum_reg, unit_accum_next;
    logic [15:0] high_unit_reg, high_unit_next;

    logic [15:0] accum_shift;
    logic [20:0] pair_cp;
    jsu_utf8_t   enc_unit;
    jsu_utf8_t   enc_pair;
    logic [3:0][7:0] bytes;
    logic [2:0]  count;

    // Shift in the next hex digit and form both possible code points
    assign accum_shift = {unit_accum_reg[11:0], hex_nibble(in_byte)};
    assign pair_cp     = {5'({1'b0, high_unit_reg[9:6]} + 5'd1),
                          high_unit_reg[5:0], accum_shift[9:0]};
    assign enc_unit    = utf8_encode({5'd0, accum_shift});
    assign enc_pair    = utf8_encode(pair_cp);

    // Next state and result bytes for the presented byte
    always_comb begin
        phase_next      = phase_reg;
        hex_count_next  = hex_count_reg;
        unit_accum_next = unit_accum_reg;
        high_unit_next  = high_unit_reg;
        bytes           = '0;
        count           = 3'd0;

        unique case (phase_reg)
            PH_ESC: begin
                if (in_byte == CH_U) begin
                    phase_next      = PH_HEX;
                    hex_count_next  = 2'd0;
                    unit_accum_next = '0;
                end else begin
                    bytes[0]   = escape_byte(in_byte);
                    count      = 3'd1;
                    phase_next = PH_TEXT;
                end
            end
            PH_HEX: begin
                unit_accum_next = accum_shift;
                if (hex_count_reg == HEX_LAST) begin
                    hex_count_next = 2'd0;
                    if ((accum_shift & SUR_MASK) == SUR_HIGH) begin
                        high_unit_next = accum_shift;
                        phase_next     = PH_SUR_BS;
                    end else begin
                        bytes      = enc_unit.bytes;
                        count      = enc_unit.count;
                        phase_next = PH_TEXT;
                    end
                end else begin
                    hex_count_next = hex_count_reg + 2'd1;
                end
            end
            PH_SUR_BS: begin
                if (in_byte == CH_BSLASH) begin
                    phase_next = PH_SUR_U;
                end else begin
                    bytes[0]   = CH_QMARK;
                    bytes[1]   = in_byte;
                    count      = 3'd2;
                    phase_next = PH_TEXT;
                end
            end
            PH_SUR_U: begin
                if (in_byte == CH_U) begin
                    phase_next      = PH_SUR_HEX;
                    hex_count_next  = 2'd0;
                    unit_accum_next = '0;
                end else begin
                    bytes[0]   = CH_QMARK;
                    bytes[1]   = escape_byte(in_byte);
                    count      = 3'd2;
                    phase_next = PH_TEXT;
                end
            end
            PH_SUR_HEX: begin
                unit_accum_next = accum_shift;
                if (hex_count_reg == HEX_LAST) begin
                    hex_count_next = 2'd0;
                    bytes          = enc_pair.bytes;
                    count          = enc_pair.count;
                    phase_next     = PH_TEXT;
                end else begin
                    hex_count_next = hex_count_reg + 2'd1;
                end
            end
            default: begin
                if (in_byte == CH_BSLASH) begin
                    phase_next = PH_ESC;
                end else begin
                    bytes[0] = in_byte;
                    count    = 3'd1;
                end
            end
        endcase

        // End of string: flush a pending surrogate as '?' and return to reset
        if (in_eos) begin
            if (phase_next == PH_SUR_BS || phase_next == PH_SUR_U ||
                phase_next == PH_SUR_HEX) begin
                bytes[count[1:0]] = CH_QMARK;
                count             = count + 3'd1;
            end
            phase_next      = PH_TEXT;
            hex_count_next  = 2'd0;
            unit_accum_next = '0;
            high_unit_next  = '0;
        end
    end

    assign group.bytes = bytes;
    assign group.count = count;
    assign group.eos   = in_eos;

    // Advance decoder state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_TEXT;
            hex_count_reg  <= 2'd0;
            unit_accum_reg <= '0;
            high_unit_reg  <= '0;
        end else if (in_fire) begin
            phase_reg      <= phase_next;
            hex_count_reg  <= hex_count_next;
            unit_accum_reg <= unit_accum_next;
            high_unit_reg  <= high_unit_next;
        end
    end

endmodule

// File: rtl/jsu_serializer.sv
module jsu_serializer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  jsu_pkg::jsu_group_t group,
    output logic               load_ready,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [7:0]         out_byte,
    output logic               out_byte_valid,
    output logic               out_done,
    output logic               out_last_of_run
);
    import jsu_pkg::*;

    logic            valid_reg, valid_next;
    logic [1:0]      idx_reg, idx_next;
    logic [1:0]      last_reg;
    logic            bare_reg;
    logic            eos_reg;
    logic [3:0][7:0] bytes_reg;

    logic at_last;

    assign at_last    = (idx_reg == last_reg);
    assign load_ready = !valid_reg || (out_ready && at_last);

    // Hold the group until its last byte is taken
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = (group.count != 3'd0) || group.eos;
            idx_next   = 2'd0;
        end else if (valid_reg && out_ready) begin
            if (at_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Capture payload of a new group
    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= group.bytes;
            eos_reg   <= group.eos;
            bare_reg  <= (group.count == 3'd0);
            last_reg  <= (group.count == 3'd0) ? 2'd0 : 2'(group.count - 3'd1);
        end
    end

    assign out_valid       = valid_reg;
    assign out_byte        = bytes_reg[idx_reg];
    assign out_byte_valid  = !bare_reg;
    assign out_last_of_run = at_last;
    assign out_done        = at_last && eos_reg;

endmodule

// File: tb/json_string_unescape_decoder_tb.sv
`timescale 1ns / 1ps

module json_string_unescape_decoder_tb;

    import jsu_pkg::*;

    // Escape letters and other characters used by the stimulus
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] ESCAPE_LETTERS [8] = '{CH_R, CH_N, CH_BSLASH, CH_SLASH,
                                                  CH_QUOTE, CH_F, CH_B, CH_T};

    localparam int RANDOM_BYTES = 390;
    localparam int HOLD_OFF_AT  = 80;
    localparam int HOLD_OFF_LEN = 400;
    localparam int DRAIN_CYCLES = 32;

    // One unescaped output byte as seen on the result channel
    typedef struct {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic       last_of_run;
    } decoded_byte_t;

    // One escaped input byte with its end-of-string flag
    typedef struct {
        logic [7:0] body_byte;
        logic       ends_string;
    } escaped_byte_t;

    class unescape_scoreboard;
        jsu_phase_t    phase;
        logic [1:0]    digit_count;
        logic [15:0]   unit_value;
        logic [15:0]   high_half;
        decoded_byte_t pending_bytes[$];
        int            mismatches;

        function new();
            clear_state();
            mismatches = 0;
        endfunction

        function void clear_state();
            phase       = PH_TEXT;
            digit_count = '0;
            unit_value  = '0;
            high_half   = '0;
        endfunction

        // Letters fold to upper case and close the gap after '9'
        function logic [3:0] digit_value(logic [7:0] c);
            logic [7:0] folded;
            folded = (c >= 8'h41) ? ({c[7:6], 1'b0, c[4:0]} - 8'd7) : c;
            return 4'(folded - 8'h30);
        endfunction

        function logic [7:0] escape_value(logic [7:0] c);
            case (c)
                CH_R:      return 8'h0D;
                CH_N:      return 8'h0A;
                CH_BSLASH: return CH_BSLASH;
                CH_SLASH:  return CH_SLASH;
                CH_QUOTE:  return CH_QUOTE;
                CH_F:      return 8'h0C;
                CH_B:      return 8'h08;
                CH_T:      return 8'h09;
                default:   return CH_QMARK;
            endcase
        endfunction

        function void push_utf8(logic [20:0] cp, ref logic [7:0] seq[$]);
            if (cp < 21'h80) begin
                seq.push_back(cp[7:0]);
            end else if (cp < 21'h800) begin
                seq.push_back({3'b110, cp[10:6]});
                seq.push_back({2'b10, cp[5:0]});
            end else if (cp < 21'h10000) begin
                seq.push_back({4'b1110, cp[15:12]});
                seq.push_back({2'b10, cp[11:6]});
                seq.push_back({2'b10, cp[5:0]});
            end else begin
                seq.push_back({5'b11110, cp[20:18]});
                seq.push_back({2'b10, cp[17:12]});
                seq.push_back({2'b10, cp[11:6]});
                seq.push_back({2'b10, cp[5:0]});
            end
        endfunction

        // Advance the decoder by one accepted input transaction
        function void take_escaped_byte(logic [7:0] c, logic eos);
            logic [7:0]    seq[$];
            logic [4:0]    plane;
            decoded_byte_t r;
            case (phase)
                PH_ESC: begin
                    if (c == CH_U) begin
                        phase       = PH_HEX;
                        digit_count = '0;
                        unit_value  = '0;
                    end else begin
                        seq.push_back(escape_value(c));
                        phase = PH_TEXT;
                    end
                end
                PH_HEX: begin
                    unit_value = {unit_value[11:0], digit_value(c)};
                    if (digit_count == HEX_LAST) begin
                        digit_count = '0;
                        if ((unit_value & SUR_MASK) == SUR_HIGH) begin
                            high_half = unit_value;
                            phase     = PH_SUR_BS;
                        end else begin
                            push_utf8({5'd0, unit_value}, seq);
                            phase = PH_TEXT;
                        end
                    end else begin
                        digit_count = digit_count + 2'd1;
                    end
                end
                PH_SUR_BS: begin
                    if (c == CH_BSLASH) begin
                        phase = PH_SUR_U;
                    end else begin
                        seq.push_back(CH_QMARK);
                        seq.push_back(c);
                        phase = PH_TEXT;
                    end
                end
                PH_SUR_U: begin
                    if (c == CH_U) begin
                        phase       = PH_SUR_HEX;
                        digit_count = '0;
                        unit_value  = '0;
                    end else begin
                        seq.push_back(CH_QMARK);
                        seq.push_back(escape_value(c));
                        phase = PH_TEXT;
                    end
                end
                PH_SUR_HEX: begin
                    unit_value = {unit_value[11:0], digit_value(c)};
                    if (digit_count == HEX_LAST) begin
                        digit_count = '0;
                        // Second unit is taken as is, only its low ten bits count
                        plane = {1'b0, high_half[9:6]} + 5'd1;
                        push_utf8({plane, high_half[5:0], unit_value[9:0]}, seq);
                        phase = PH_TEXT;
                    end else begin
                        digit_count = digit_count + 2'd1;
                    end
                end
                default: begin
                    if (c == CH_BSLASH) begin
                        phase = PH_ESC;
                    end else begin
                        seq.push_back(c);
                    end
                end
            endcase

            // End of string: flush a waiting surrogate, drop a cut escape
            if (eos) begin
                if (phase inside {PH_SUR_BS, PH_SUR_U, PH_SUR_HEX}) begin
                    seq.push_back(CH_QMARK);
                end
                clear_state();
            end

            if (seq.size() == 0) begin
                if (eos) begin
                    r = '{out_byte: 8'h00, byte_valid: 1'b0, string_done: 1'b1,
                          last_of_run: 1'b1};
                    pending_bytes.push_back(r);
                end
            end else begin
                foreach (seq[k]) begin
                    r.out_byte    = seq[k];
                    r.byte_valid  = 1'b1;
                    r.last_of_run = (k == seq.size() - 1);
                    r.string_done = r.last_of_run && eos;
                    pending_bytes.push_back(r);
                end
            end
        endfunction

        // Compare one output transaction against the oldest expected byte
        function void check_unescaped_byte(logic [7:0] ob, logic bv, logic sd, logic lr);
            decoded_byte_t r;
            if (pending_bytes.size() == 0) begin
                $error("unexpected output: out_byte %02h byte_valid %0b", ob, bv);
                mismatches++;
                return;
            end
            r = pending_bytes.pop_front();
            if (ob !== r.out_byte) begin
                $error("out_byte expected %02h actual %02h", r.out_byte, ob);
                mismatches++;
            end
            if (bv !== r.byte_valid) begin
                $error("byte_valid expected %0b actual %0b", r.byte_valid, bv);
                mismatches++;
            end
            if (sd !== r.string_done) begin
                $error("string_done expected %0b actual %0b", r.string_done, sd);
                mismatches++;
            end
            if (lr !== r.last_of_run) begin
                $error("last_of_run expected %0b actual %0b", r.last_of_run, lr);
                mismatches++;
            end
        endfunction

        function int waiting();
            return pending_bytes.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_tlast  = 1'b0;    // end_of_string
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] out_byte, [8] last_of_run, [15:9] zero
    logic        m_tuser;            // [0] byte_valid
    logic        m_tlast;            // string_done

    unescape_scoreboard sb = new();
    escaped_byte_t      escaped_stream[$];
    int                 cut_odds = 0;

    json_string_unescape_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Idle gaps come in stretches: every third block of transactions has none
    function automatic int draw_gap(int n);
        if ((n / 32) % 3 == 2) begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Append a byte; in the random part a string may end on any byte
    function automatic void push_byte(logic [7:0] c);
        escaped_byte_t e;
        e.body_byte   = c;
        e.ends_string = (cut_odds != 0) && ($urandom_range(1, cut_odds) == 1);
        escaped_stream.push_back(e);
    endfunction

    function automatic void end_string();
        escaped_stream[escaped_stream.size() - 1].ends_string = 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) begin
            return CH_ZERO + 8'(nib);
        end
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(nib) - 8'd10;
    endfunction

    // Emit \uXXXX; in the random part a digit is now and then garbage
    function automatic void push_unit(logic [15:0] unit);
        push_byte(CH_BSLASH);
        push_byte(CH_U);
        for (int k = 3; k >= 0; k--) begin
            if (cut_odds != 0 && $urandom_range(0, 39) == 0) begin
                push_byte(8'($urandom_range(0, 255)));
            end else begin
                push_byte(hex_char(unit[k*4 +: 4]));
            end
        end
    endfunction

    function automatic void build_directed();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_BSLASH);
        push_byte(CH_N);
        push_byte(CH_BSLASH);
        push_byte(CH_Q);
        // two-byte sequence, then a surrogate pair into four bytes
        push_unit(16'h00E9);
        push_unit(16'hD83D);
        push_unit(16'hDE00);
        // lone high surrogate followed by plain text
        push_unit(16'hD800);
        push_byte(CH_X);
        // string ends right after a backslash
        push_byte(CH_BSLASH);
        end_string();
    endfunction

    function automatic void build_random();
        int          pick;
        logic [15:0] unit;
        cut_odds = 50;
        while (escaped_stream.size() < RANDOM_BYTES + 32) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                push_byte(8'($urandom_range(0, 255)));
            end else if (pick < 55) begin
                push_byte(CH_BSLASH);
                if ($urandom_range(0, 4) == 0) begin
                    push_byte(8'($urandom_range(0, 255)));
                end else begin
                    push_byte(ESCAPE_LETTERS[$urandom_range(0, 7)]);
                end
            end else if (pick < 72) begin
                case ($urandom_range(0, 4))
                    0:       unit = 16'h0000;
                    1:       unit = 16'($urandom_range(1, 16'h7F));
                    2:       unit = 16'($urandom_range(16'h80, 16'h7FF));
                    default: unit = 16'($urandom_range(16'h800, 16'hFFFF));
                endcase
                push_unit(unit);
            end else if (pick < 87) begin
                push_unit(SUR_HIGH | 16'($urandom_range(0, 16'h3FF)));
                if ($urandom_range(0, 5) == 0) begin
                    push_unit(16'($urandom_range(0, 16'hFFFF)));
                end else begin
                    push_unit(16'hDC00 | 16'($urandom_range(0, 16'h3FF)));
                end
            end else begin
                // high surrogate without its partner
                push_unit(SUR_HIGH | 16'($urandom_range(0, 16'h3FF)));
                case ($urandom_range(0, 2))
                    0: push_byte(8'($urandom_range(0, 255)));
                    1: begin
                        push_byte(CH_BSLASH);
                        push_byte(ESCAPE_LETTERS[$urandom_range(0, 7)]);
                    end
                    default: begin
                        push_byte(CH_BSLASH);
                        push_byte(8'($urandom_range(0, 255)));
                    end
                endcase
            end
            if ($urandom_range(0, 9) == 0) begin
                end_string();
            end
        end
    endfunction

    // Record every handshake on both channels at the clock edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.take_escaped_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                sb.check_unescaped_byte(m_tdata[7:0], m_tuser, m_tlast, m_tdata[8]);
            end
        end
    end

    // Feed the escaped stream, then drain and report
    initial begin
        int gap;
        build_directed();
        build_random();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (escaped_stream[i]) begin
            gap = draw_gap(i);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= escaped_stream[i].body_byte;
            s_tlast  <= escaped_stream[i].ends_string;
            do @(posedge aclk); while (s_tready !== 1'b1);
        end
        s_tvalid <= 1'b0;
        // Let the monitor record the final input transaction first
        @(posedge aclk);
        while (sb.waiting() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Accept output transactions with random stalls and one long hold-off
    initial begin
        int gap;
        int taken;
        taken = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = (taken == HOLD_OFF_AT) ? HOLD_OFF_LEN : draw_gap(taken);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            taken++;
        end
    end

    // Hard stop in case the handshakes hang
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_serializer.sv
rtl/json_string_unescape_decoder.sv
tb/json_string_unescape_decoder_tb.sv
